// File: hw/rtl/cht_pkg.sv
// Shared types and constants for the chained hash table unit.
package cht_pkg;

    localparam int KEY_W = 31;
    localparam int HEAD_W = 32;
    localparam int BC_W = 8;
    localparam int STATUS_W = 2;
    localparam int BIDX_W = 7;
    localparam logic [BC_W-1:0] BC_RESET = 8'd13;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [HEAD_W-1:0] HEAD_DELETED = '1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture request, start modulo
        logic div_step;    // one restoring-division step
        logic clr_step;    // one clear pass step
        logic rd_bucket;   // read head and length of bucket
        logic chk_head;    // evaluate head, prime chain scan
        logic scan_rd;     // issue chain read at scan index
        logic scan_chk;    // compare chain data, advance
        logic shift_rd;    // read entry at index+1 for compaction
        logic shift_wr;    // write shifted entry, advance
        logic finish;      // latch result into output register
    } cht_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic clr_done;
        logic key_zero;
        logic mode_bad;
        logic mode_rm;     // request is a removal
        logic head_done;   // head step decided the request
        logic chain_none;  // chain is empty, nothing to scan
        logic scan_hit;
        logic scan_end;
        logic shift_last;
    } cht_sts_t;

endpackage

// File: hw/rtl/cht_ctrl.sv
// Controller state machine for the chained hash table unit.
module cht_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  cht_pkg::cht_sts_t sts,
    output cht_pkg::cht_cmd_t cmd
);
    import cht_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_RDB, S_HEAD, S_SRD, S_SCHK,
        S_HRD, S_HWR, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    assign out_valid = ov_reg;
    // accept a new request whenever idle; S_FIN waits for the output slot
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ov_next = ov_reg && out_stall;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.rd_bucket = 1'b1;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.chk_head = 1'b1;
                if (sts.key_zero || sts.mode_bad || sts.head_done || sts.chain_none)
                    state_next = S_FIN;
                else
                    state_next = S_SRD;
            end
            S_SRD:
            begin
                cmd.scan_rd = 1'b1;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                cmd.scan_chk = 1'b1;
                priority if (sts.scan_hit && (sts.shift_last || !sts.mode_rm))
                    state_next = S_FIN;
                else if (sts.scan_hit)
                    state_next = S_HRD;
                else if (sts.scan_end)
                    state_next = S_FIN;
                else
                    state_next = S_SRD;
            end
            S_HRD:
            begin
                cmd.shift_rd = 1'b1;
                state_next = S_HWR;
            end
            S_HWR:
            begin
                cmd.shift_wr = 1'b1;
                state_next = sts.shift_last ? S_FIN : S_HRD;
            end
            S_FIN:
            begin
                if (!ov_next)
                begin
                    cmd.finish = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

endmodule

// File: hw/rtl/cht_dp.sv
// Datapath: modulo unit, bucket stores and chain scan for the hash table.
module cht_dp
#(
    parameter int BUCKETS = 128,
    parameter int CHAIN_DEPTH = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cht_pkg::cht_cmd_t                   cmd,
    output cht_pkg::cht_sts_t                   sts,
    input  logic [cht_pkg::BC_W-1:0]            cfg_bc,
    input  logic [1:0]                          in_mode,
    input  logic [cht_pkg::KEY_W-1:0]           in_key,
    output logic [cht_pkg::STATUS_W-1:0]        res_status,
    output logic [cht_pkg::BIDX_W-1:0]          res_bidx
);
    import cht_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int LW = $clog2(CHAIN_DEPTH + 1);
    localparam int DW = KEY_W + 1;
    localparam int SW = $clog2(KEY_W + 1);
    localparam int CLW = BW + CW;
    localparam logic [CLW:0] CLR_LAST = (CLW+1)'(BUCKETS * (1 << CW) - 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(CHAIN_DEPTH);

    // each bucket owns a power-of-two block of chain slots
    logic [HEAD_W-1:0] head_mem [BUCKETS];
    logic [KEY_W-1:0]  chain_mem [BUCKETS << CW];
    logic [LW-1:0]     len_mem [BUCKETS];

    logic [KEY_W-1:0] key_reg;
    logic [1:0]       mode_reg;
    logic [DW-1:0]    rem_reg;
    logic [SW-1:0]    dcnt_reg;
    logic [CLW:0]     clr_reg;
    logic [BW-1:0]    b_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [LW-1:0]    len_reg;
    logic [LW-1:0]    idx_reg;
    logic [KEY_W-1:0] crd_reg;
    logic [STATUS_W-1:0] st_reg;

    // effective modulus: clamp zero to one, saturate at BUCKETS
    logic [DW-1:0] modv;
    always_comb
    begin
        if (cfg_bc == '0)
            modv = DW'(1);
        else if (32'(cfg_bc) > BUCKETS)
            modv = DW'(BUCKETS);
        else
            modv = DW'(cfg_bc);
    end

    // restoring division, one quotient bit a cycle (remainder only)
    logic [DW-1:0] trial;
    logic [DW-1:0] rem_sh;
    logic [SW-1:0] kbit;
    assign kbit = SW'(KEY_W - 1) - dcnt_reg;
    assign rem_sh = {rem_reg[DW-2:0], key_reg[kbit]};
    assign trial = rem_sh - modv;

    logic [CLW-1:0] base_addr, scan_addr;
    assign base_addr = CLW'(b_reg) << CW;
    assign scan_addr = base_addr + CLW'(idx_reg[CW-1:0]);

    logic head_free, head_hit, len_full;
    assign head_free = (head_reg == '0) || (head_reg == HEAD_DELETED);
    assign head_hit = (head_reg == {1'b0, key_reg});
    assign len_full = (len_reg >= DEPTH_L);

    always_comb
    begin
        sts = '0;
        sts.div_done = (dcnt_reg == SW'(KEY_W - 1));
        sts.clr_done = (clr_reg == CLR_LAST);
        sts.key_zero = (key_reg == '0);
        sts.mode_bad = (mode_reg != MODE_INSERT) && (mode_reg != MODE_SEARCH)
                       && (mode_reg != MODE_REMOVE);
        sts.mode_rm = (mode_reg == MODE_REMOVE);
        sts.head_done = (mode_reg == MODE_INSERT) || head_hit;
        sts.chain_none = (len_reg == '0);
        sts.scan_hit = (crd_reg == key_reg);
        sts.scan_end = (idx_reg + LW'(1) >= len_reg);
        sts.shift_last = (idx_reg + LW'(1) >= len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_step && !sts.clr_done)
            clr_reg <= clr_reg + (CLW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            chain_mem[clr_reg[CLW-1:0]] <= '0;
            if (clr_reg[CW-1:0] == '0)
            begin
                head_mem[clr_reg[CLW-1:CW]] <= '0;
                len_mem[clr_reg[CLW-1:CW]] <= '0;
            end
        end
        if (cmd.load)
        begin
            key_reg <= in_key;
            mode_reg <= in_mode;
            rem_reg <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial[DW-1] ? rem_sh : trial;
            dcnt_reg <= dcnt_reg + SW'(1);
            if (sts.div_done)
                b_reg <= BW'(trial[DW-1] ? rem_sh : trial);
        end
        if (cmd.rd_bucket)
        begin
            head_reg <= head_mem[b_reg];
            len_reg <= len_mem[b_reg];
        end
        if (cmd.chk_head)
        begin
            idx_reg <= '0;
            if (key_reg == '0)
                st_reg <= ST_MISS;
            else
            begin
                unique case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (head_free)
                        begin
                            head_mem[b_reg] <= {1'b0, key_reg};
                            st_reg <= ST_OK;
                        end
                        else if (len_full)
                            st_reg <= ST_FULL;
                        else
                        begin
                            chain_mem[base_addr + CLW'(len_reg[CW-1:0])] <= key_reg;
                            len_mem[b_reg] <= len_reg + LW'(1);
                            st_reg <= ST_OK;
                        end
                    end
                    MODE_SEARCH:
                        st_reg <= head_hit ? ST_OK : ST_MISS;
                    MODE_REMOVE:
                        if (head_hit)
                        begin
                            head_mem[b_reg] <= HEAD_DELETED;
                            st_reg <= ST_OK;
                        end
                        else
                            st_reg <= ST_MISS;
                    default: st_reg <= ST_MISS;
                endcase
            end
        end
        if (cmd.scan_rd)
            crd_reg <= chain_mem[scan_addr];
        if (cmd.scan_chk)
        begin
            if (sts.scan_hit)
            begin
                st_reg <= ST_OK;
                if (mode_reg == MODE_REMOVE)
                begin
                    len_mem[b_reg] <= len_reg - LW'(1);
                    if (sts.shift_last)
                        chain_mem[scan_addr] <= '0;
                end
            end
            else
                idx_reg <= idx_reg + LW'(1);
        end
        if (cmd.shift_rd)
            crd_reg <= chain_mem[scan_addr + CLW'(1)];
        if (cmd.shift_wr)
        begin
            // last round clears the freed tail slot
            if (sts.shift_last)
                chain_mem[scan_addr] <= '0;
            else
                chain_mem[scan_addr] <= crd_reg;
            idx_reg <= idx_reg + LW'(1);
        end
        if (cmd.finish)
        begin
            res_status <= st_reg;
            res_bidx <= BIDX_W'(b_reg);
        end
    end

endmodule

// File: hw/rtl/chained_hash_table_unit.sv
// A request passes the modulo, a bucket read and the head check; a search or
// removal not decided at the head then scans the chain entry by entry, and a
// removal inside the chain moves each later entry up and clears the freed tail. One
// request at a time; the bit-serial modulo (31 steps) and one chain memory port set
// its pace. A result waits in an output register while the next request is taken.
// Reset (rst_n, async) clears control at once; a clearing pass over BUCKETS times
// CHAIN_DEPTH (rounded up to a power of two) chain slots zeroes the stores first.
module chained_hash_table_unit
#(
    parameter int BUCKETS = 128,
    parameter int CHAIN_DEPTH = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cht_pkg::BC_W-1:0]         cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       mode,
    input  logic [cht_pkg::KEY_W-1:0]        key,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [cht_pkg::STATUS_W-1:0]     status,
    output logic [cht_pkg::BIDX_W-1:0]       bucket_index
);
    import cht_pkg::*;

    cht_cmd_t cmd;
    cht_sts_t sts;
    logic [BC_W-1:0] bc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bc_reg <= BC_RESET;
        else if (cfg_we)
            bc_reg <= cfg_wdata;
    end

    cht_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
    );

    cht_dp #(.BUCKETS(BUCKETS), .CHAIN_DEPTH(CHAIN_DEPTH)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cfg_bc(bc_reg),
        .in_mode(mode), .in_key(key), .res_status(status),
        .res_bidx(bucket_index)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.div_step, cmd.clr_step, cmd.chk_head,
                    cmd.scan_chk, cmd.finish}) <= 1)
        else $error("more than one command active");

    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result not presented after finish");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> in_stall)
        else $error("request taken while busy");

endmodule

// File: verif/chained_hash_table_checker.sv
// Checker for the chained hash table unit: shadow table, prediction and compare.
`timescale 1ns / 100ps
module chained_hash_table_checker
#(
    parameter int BUCKETS = 128,
    parameter int CHAIN_DEPTH = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cht_pkg::BC_W-1:0]     cfg_wdata,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [cht_pkg::KEY_W-1:0]    key,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [cht_pkg::STATUS_W-1:0] status,
    input  logic [cht_pkg::BIDX_W-1:0]   bucket_index,
    output int                           fail_count,
    output int                           pending
);
    import cht_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BIDX_W-1:0]   bucket_index;
    } table_result_t;

    logic [HEAD_W-1:0] shadow_head [BUCKETS];
    logic [KEY_W-1:0]  shadow_chain [BUCKETS][CHAIN_DEPTH];
    int                shadow_len [BUCKETS];
    logic [BC_W-1:0]   shadow_bc;
    table_result_t     expected_results [$];

    assign pending = expected_results.size();

    function automatic table_result_t apply_request(logic [1:0] m, logic [KEY_W-1:0] k);
        table_result_t r;
        int nb;
        int b;
        int len;
        int hit;
        nb = (shadow_bc == 0) ? 1 : ((shadow_bc > BUCKETS) ? BUCKETS : shadow_bc);
        b = k % nb;
        len = shadow_len[b];
        hit = -1;
        r.bucket_index = b[BIDX_W-1:0];
        r.status = ST_MISS;
        if (k != 0) begin
            for (int i = len - 1; i >= 0; i--)
                if (shadow_chain[b][i] == k) hit = i;
            if (m == MODE_INSERT) begin
                if (shadow_head[b] == '0 || shadow_head[b] == HEAD_DELETED) begin
                    shadow_head[b] = {1'b0, k};
                    r.status = ST_OK;
                end
                else if (len >= CHAIN_DEPTH) begin
                    r.status = ST_FULL;
                end
                else begin
                    shadow_chain[b][len] = k;
                    shadow_len[b] = len + 1;
                    r.status = ST_OK;
                end
            end
            else if (m == MODE_SEARCH) begin
                if (shadow_head[b] == {1'b0, k} || hit >= 0) r.status = ST_OK;
            end
            else if (m == MODE_REMOVE) begin
                if (shadow_head[b] == {1'b0, k}) begin
                    shadow_head[b] = HEAD_DELETED;
                    r.status = ST_OK;
                end
                else if (hit >= 0) begin
                    for (int j = hit; j + 1 < len; j++)
                        shadow_chain[b][j] = shadow_chain[b][j+1];
                    shadow_chain[b][len-1] = '0;
                    shadow_len[b] = len - 1;
                    r.status = ST_OK;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t exp_r;
        int errs;
        errs = 0;
        if (!rst_n) begin
            fail_count <= 0;
            shadow_bc = BC_RESET;
            expected_results.delete();
            for (int b = 0; b < BUCKETS; b++) begin
                shadow_head[b] = '0;
                shadow_len[b] = 0;
                for (int i = 0; i < CHAIN_DEPTH; i++) shadow_chain[b][i] = '0;
            end
        end
        else begin
            if (cfg_we) shadow_bc = cfg_wdata;
            if (in_valid && !in_stall) expected_results.push_back(apply_request(mode, key));
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result status=%0d bucket_index=%0d",
                           status, bucket_index);
                    errs++;
                end
                else begin
                    exp_r = expected_results.pop_front();
                    if (status !== exp_r.status) begin
                        $error("status expected %0d actual %0d", exp_r.status, status);
                        errs++;
                    end
                    if (bucket_index !== exp_r.bucket_index) begin
                        $error("bucket_index expected %0d actual %0d",
                               exp_r.bucket_index, bucket_index);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

// File: verif/chained_hash_table_unit_tb.sv
// Testbench top for the chained hash table unit: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module chained_hash_table_unit_tb;
    import cht_pkg::*;

    localparam int BUCKETS = 128;
    localparam int CHAIN_DEPTH = 8;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 200;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [BC_W-1:0]     cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          mode;
    logic [KEY_W-1:0]    key;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   bucket_index;
    int                  fail_count;
    int                  pending;
    int                  cycle_count;
    bit                  hold_long;
    bit                  allow_stall;
    logic [KEY_W-1:0]    recent_keys [$];

    chained_hash_table_unit #(.BUCKETS(BUCKETS), .CHAIN_DEPTH(CHAIN_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .key(key),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .bucket_index(bucket_index)
    );

    chained_hash_table_checker #(.BUCKETS(BUCKETS), .CHAIN_DEPTH(CHAIN_DEPTH)) checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .key(key),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .bucket_index(bucket_index), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls; one long hold-off when requested
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long) begin
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
                hold_long = 1'b0;
            end
            else if (allow_stall && $urandom_range(0, 3) == 0) begin
                n = gap_len() + 1;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else begin
                @(posedge clk);
            end
        end
    end

    // valid stays up across back-to-back requests; dropped only for a gap
    task automatic send_request(input logic [1:0] m, input logic [KEY_W-1:0] k);
        int n;
        n = gap_len();
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        key <= k;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_bucket_count(input logic [BC_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int nb);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if (r < 8)
            return KEY_W'($urandom_range(0, 3) * nb + $urandom_range(0, 1));
        if (r < 9) return $urandom_range(0, 1) ? {KEY_W{1'b1}} : KEY_W'(0);
        return KEY_W'($urandom());
    endfunction

    task automatic random_phase(input logic [BC_W-1:0] bc, input int count);
        int nb;
        logic [1:0] m;
        logic [KEY_W-1:0] k;
        nb = (bc == 0) ? 1 : ((bc > BUCKETS) ? BUCKETS : bc);
        recent_keys.delete();
        for (int i = 0; i < count; i++)
        begin
            k = pick_key(nb);
            case ($urandom_range(0, 19))
                0: m = MODE_UNUSED;
                1, 2, 3, 4, 5, 6, 7, 8: m = MODE_INSERT;
                9, 10, 11, 12, 13: m = MODE_SEARCH;
                default: m = MODE_REMOVE;
            endcase
            if (m == MODE_INSERT && k != 0) begin
                recent_keys.push_back(k);
                if (recent_keys.size() > 24) void'(recent_keys.pop_front());
            end
            send_request(m, k);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        mode = MODE_INSERT;
        key = '0;
        hold_long = 1'b0;
        allow_stall = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset modulus 13, head, chain, full chain, deletes, bad cases
        send_request(MODE_INSERT, KEY_W'(0));
        send_request(MODE_SEARCH, KEY_W'(0));
        send_request(MODE_REMOVE, KEY_W'(0));
        send_request(MODE_UNUSED, KEY_W'(5));
        for (int i = 0; i < 10; i++) send_request(MODE_INSERT, KEY_W'(13 * i + 13));
        send_request(MODE_INSERT, KEY_W'(13));
        send_request(MODE_SEARCH, KEY_W'(13 * 5 + 13));
        send_request(MODE_REMOVE, KEY_W'(13 * 3 + 13));
        send_request(MODE_REMOVE, KEY_W'(13));
        send_request(MODE_SEARCH, KEY_W'(13));
        send_request(MODE_INSERT, {KEY_W{1'b1}});
        send_request(MODE_SEARCH, {KEY_W{1'b1}});
        send_request(MODE_REMOVE, {KEY_W{1'b1}});
        send_request(MODE_REMOVE, KEY_W'(999));
        send_request(MODE_SEARCH, KEY_W'(1));
        wait_idle();

        allow_stall = 1'b1;
        // block fills while receiver holds off
        hold_long = 1'b1;
        random_phase(8'd13, 150);
        wait_idle();

        write_bucket_count(8'd0);
        random_phase(8'd0, 150);
        wait_idle();
        write_bucket_count(8'd1);
        random_phase(8'd1, 150);
        wait_idle();
        write_bucket_count(8'd255);
        random_phase(8'd255, 300);
        wait_idle();
        write_bucket_count(8'd128);
        random_phase(8'd128, 300);
        wait_idle();
        write_bucket_count(8'd129);
        random_phase(8'd129, 150);
        wait_idle();
        write_bucket_count(8'd2);
        random_phase(8'd2, 200);
        wait_idle();
        write_bucket_count(8'd77);
        random_phase(8'd77, 330);
        wait_idle();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cht_pkg.sv
hw/rtl/cht_ctrl.sv
hw/rtl/cht_dp.sv
hw/rtl/chained_hash_table_unit.sv
verif/chained_hash_table_checker.sv
verif/chained_hash_table_unit_tb.sv
